/* rtl/tlsx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlsx_pkg
// Shared types and constants of the handshake message extractor.
// ----------------------------------------------------------------------------
package tlsx_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MAJOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MINOR = 2'd2;

  localparam logic [BYTE_W-1:0] SYNC_TYPE_RST  = 8'h16;
  localparam logic [BYTE_W-1:0] SYNC_MAJOR_RST = 8'h03;
  localparam logic [BYTE_W-1:0] SYNC_MINOR_RST = 8'h03;

  // Handshake message types.
  localparam logic [BYTE_W-1:0] KIND_SERVER_HELLO = 8'h02;
  localparam logic [BYTE_W-1:0] KIND_CERTIFICATE  = 8'h0b;
  localparam logic [BYTE_W-1:0] KIND_CERT_STATUS  = 8'h16;
  localparam logic [BYTE_W-1:0] KIND_KEY_EXCHANGE = 8'h0c;
  localparam logic [BYTE_W-1:0] KIND_HELLO_DONE   = 8'h0e;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_RECLEN,
    PH_TYPE,
    PH_HSLEN,
    PH_BODY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] content_type;
    logic [BYTE_W-1:0] version_major;
    logic [BYTE_W-1:0] version_minor;
  } sync_cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic [BYTE_W-1:0] message_kind;
    logic              first_of_message;
    logic              last_of_message;
    logic              hello_done;
  } result_t;

  function automatic logic kind_accepted(input logic [BYTE_W-1:0] k);
    return (k == KIND_SERVER_HELLO) || (k == KIND_CERTIFICATE) ||
           (k == KIND_CERT_STATUS) || (k == KIND_KEY_EXCHANGE);
  endfunction

endpackage
`default_nettype wire

/* rtl/tlsx_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlsx_parser
// Front end: hunts for the record header, walks the handshake header and
// classifies each body byte, pushing one result per emitted byte.
// ----------------------------------------------------------------------------
module tlsx_parser (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tlsx_pkg::sync_cfg_t       sync_cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [tlsx_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                      queue_full,
  output logic                           push,
  output tlsx_pkg::result_t              push_data
);
  import tlsx_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [2*BYTE_W-1:0] recent_r, recent_nxt;
  logic [1:0]         count_r, count_nxt;
  logic [BYTE_W-1:0]  kind_r, kind_nxt;
  logic [LEN_W-1:0]   remaining_r, remaining_nxt;
  logic               start_r, start_nxt;
  logic               accept;
  logic [LEN_W-1:0]   len_shift;

  assign in_ready  = !queue_full;
  assign accept    = in_valid && in_ready;
  assign len_shift = {remaining_r[LEN_W-BYTE_W-1:0], in_byte};

  always_comb begin
    phase_nxt     = phase_r;
    recent_nxt    = recent_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    remaining_nxt = remaining_r;
    start_nxt     = start_r;
    push          = 1'b0;
    push_data     = '0;
    if (accept) begin
      case (phase_r)
        PH_SEARCH: begin
          if ((count_r == 2'd2) && (recent_r[2*BYTE_W-1:BYTE_W] == sync_cfg.content_type) &&
              (recent_r[BYTE_W-1:0] == sync_cfg.version_major) &&
              (in_byte == sync_cfg.version_minor)) begin
            phase_nxt  = PH_RECLEN;
            recent_nxt = '0;
            count_nxt  = '0;
          end else begin
            recent_nxt = {recent_r[BYTE_W-1:0], in_byte};
            if (count_r != 2'd2) count_nxt = count_r + 2'd1;
          end
        end
        PH_RECLEN: begin
          if (count_r == 2'd1) begin
            phase_nxt = PH_TYPE;
            count_nxt = '0;
          end else begin
            count_nxt = count_r + 2'd1;
          end
        end
        PH_TYPE: begin
          kind_nxt      = in_byte;
          remaining_nxt = '0;
          count_nxt     = '0;
          phase_nxt     = PH_HSLEN;
        end
        PH_HSLEN: begin
          remaining_nxt = len_shift;
          count_nxt     = count_r + 2'd1;
          if (count_r == 2'd2) begin
            count_nxt = '0;
            if (kind_r == KIND_HELLO_DONE) begin
              push                   = 1'b1;
              push_data.message_kind = KIND_HELLO_DONE;
              push_data.hello_done   = 1'b1;
              phase_nxt              = PH_DONE;
            end else if (len_shift == '0) begin
              phase_nxt  = PH_SEARCH;
              recent_nxt = '0;
            end else begin
              start_nxt = 1'b1;
              phase_nxt = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (kind_accepted(kind_r)) begin
            push                       = 1'b1;
            push_data.body_byte        = in_byte;
            push_data.message_kind     = kind_r;
            push_data.first_of_message = start_r;
            push_data.last_of_message  = (remaining_r == LEN_W'(1));
          end
          start_nxt     = 1'b0;
          remaining_nxt = remaining_r - LEN_W'(1);
          if (remaining_r == LEN_W'(1)) begin
            phase_nxt  = PH_SEARCH;
            recent_nxt = '0;
            count_nxt  = '0;
          end
        end
        PH_DONE: begin
          phase_nxt = PH_DONE;
        end
        default: begin
          phase_nxt = PH_SEARCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      recent_r    <= '0;
      count_r     <= '0;
      kind_r      <= '0;
      remaining_r <= '0;
      start_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      recent_r    <= recent_nxt;
      count_r     <= count_nxt;
      kind_r      <= kind_nxt;
      remaining_r <= remaining_nxt;
      start_r     <= start_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/tlsx_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlsx_queue
// Back end: a short result queue whose head drives the output channel, so
// the parser and the consumer stall independently.
// ----------------------------------------------------------------------------
module tlsx_queue #(
  parameter int unsigned DEPTH = tlsx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire tlsx_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tlsx_pkg::result_t      head
);
  import tlsx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  result_t          store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign full      = (count_r == CNT_FULL);
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign head      = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) store_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

/* rtl/tls_handshake_message_extractor_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tls_handshake_message_extractor_top
// Extracts handshake message bodies from a received record byte stream.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_ready   in_byte
//  out_     output     out_valid / out_ready body byte, kind, first, last, done
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is taken every cycle while the queue has room; a result is written
// into the result queue as its byte is taken. in_ready drops only when the
// queue holds QUEUE_DEPTH results that the consumer has not taken. Reset is
// synchronous and leaves the block searching for a header with the default
// pattern. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module tls_handshake_message_extractor_top #(
  parameter int unsigned QUEUE_DEPTH = tlsx_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tlsx_pkg::BYTE_W-1:0]    in_byte,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tlsx_pkg::BYTE_W-1:0]         out_body_byte,
  output logic [tlsx_pkg::BYTE_W-1:0]         out_message_kind,
  output logic                                out_first_of_message,
  output logic                                out_last_of_message,
  output logic                                out_hello_done,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tlsx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tlsx_pkg::BYTE_W-1:0]    cfg_data
);
  import tlsx_pkg::*;

  sync_cfg_t sync_r;
  logic      queue_full;
  logic      push;
  result_t   push_data;
  result_t   head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r.content_type  <= SYNC_TYPE_RST;
      sync_r.version_major <= SYNC_MAJOR_RST;
      sync_r.version_minor <= SYNC_MINOR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC_TYPE:  sync_r.content_type  <= cfg_data;
        CFG_SYNC_MAJOR: sync_r.version_major <= cfg_data;
        CFG_SYNC_MINOR: sync_r.version_minor <= cfg_data;
        default: ;
      endcase
    end
  end

  tlsx_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .sync_cfg   (sync_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  tlsx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_body_byte        = head.body_byte;
  assign out_message_kind     = head.message_kind;
  assign out_first_of_message = head.first_of_message;
  assign out_last_of_message  = head.last_of_message;
  assign out_hello_done       = head.hello_done;

endmodule
`default_nettype wire

/* dv/handshake_extract_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handshake_extract_checker
// Watches the byte, result and register channels of the extractor, tracks the
// record and handshake framing of the accepted bytes, and compares every
// result taken at the output with the oldest predicted one.
// ----------------------------------------------------------------------------
module handshake_extract_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [tlsx_pkg::BYTE_W-1:0]    in_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tlsx_pkg::BYTE_W-1:0]    out_body_byte,
  input  logic [tlsx_pkg::BYTE_W-1:0]    out_message_kind,
  input  logic                           out_first_of_message,
  input  logic                           out_last_of_message,
  input  logic                           out_hello_done,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tlsx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlsx_pkg::BYTE_W-1:0]    cfg_data,
  output int                             error_count,
  output int                             extracts_pending
);
  import tlsx_pkg::*;

  sync_cfg_t         pattern;
  phase_t            stage;
  logic [15:0]       window;
  logic [2:0]        fill;
  logic [BYTE_W-1:0] msg_kind;
  logic [LEN_W-1:0]  bytes_left;
  logic              body_start;
  logic              done_seen;
  result_t           extracts_due[$];
  int                mismatches = 0;

  // The search window starts out empty whenever the hunt for a header begins.
  task automatic restart_hunt();
    stage  = PH_SEARCH;
    window = '0;
    fill   = '0;
  endtask

  task automatic parse_stream_byte(input logic [BYTE_W-1:0] b);
    result_t r;
    if (done_seen || stage == PH_DONE) return;
    case (stage)
      PH_RECLEN: begin
        fill = fill + 3'd1;
        if (fill >= 3'd2) begin
          stage = PH_TYPE;
          fill  = '0;
        end
      end
      PH_TYPE: begin
        msg_kind   = b;
        bytes_left = '0;
        fill       = '0;
        stage      = PH_HSLEN;
      end
      PH_HSLEN: begin
        bytes_left = {bytes_left[LEN_W-BYTE_W-1:0], b};
        fill = fill + 3'd1;
        if (fill >= 3'd3) begin
          fill = '0;
          if (msg_kind == KIND_HELLO_DONE) begin
            // The done message ends the stream whatever its length says.
            r = '0;
            r.message_kind = KIND_HELLO_DONE;
            r.hello_done   = 1'b1;
            extracts_due = {extracts_due, r};
            done_seen = 1'b1;
            stage     = PH_DONE;
          end else if (bytes_left == '0) begin
            restart_hunt();
          end else begin
            body_start = 1'b1;
            stage      = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        case (msg_kind)
          KIND_SERVER_HELLO, KIND_CERTIFICATE, KIND_CERT_STATUS, KIND_KEY_EXCHANGE: begin
            r.body_byte        = b;
            r.message_kind     = msg_kind;
            r.first_of_message = body_start;
            r.last_of_message  = (bytes_left == LEN_W'(1));
            r.hello_done       = 1'b0;
            extracts_due = {extracts_due, r};
          end
          default: ;
        endcase
        body_start = 1'b0;
        bytes_left = bytes_left - LEN_W'(1);
        if (bytes_left == '0) restart_hunt();
      end
      default: begin
        if (fill >= 3'd2 && window[15:8] == pattern.content_type &&
            window[7:0] == pattern.version_major && b == pattern.version_minor) begin
          stage  = PH_RECLEN;
          window = '0;
          fill   = '0;
        end else begin
          stage  = PH_SEARCH;
          window = {window[7:0], b};
          if (fill < 3'd2) fill = fill + 3'd1;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input logic had_want, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      if (had_want)
        $display("%0t MISMATCH expected byte %02h kind %02h first %0b last %0b done %0b,",
                 $time, want.body_byte, want.message_kind, want.first_of_message,
                 want.last_of_message, want.hello_done,
                 " got byte %02h kind %02h first %0b last %0b done %0b",
                 got.body_byte, got.message_kind, got.first_of_message,
                 got.last_of_message, got.hello_done);
      else
        $display("%0t MISMATCH unexpected result byte %02h kind %02h first %0b",
                 $time, got.body_byte, got.message_kind, got.first_of_message,
                 " last %0b done %0b", got.last_of_message, got.hello_done);
    end
  endtask

  always @(posedge clk) begin : track
    result_t got;
    result_t want;
    if (!rst_n) begin
      pattern = {SYNC_TYPE_RST, SYNC_MAJOR_RST, SYNC_MINOR_RST};
      restart_hunt();
      msg_kind   = '0;
      bytes_left = '0;
      body_start = 1'b0;
      done_seen  = 1'b0;
      extracts_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SYNC_TYPE:  pattern.content_type  = cfg_data;
          CFG_SYNC_MAJOR: pattern.version_major = cfg_data;
          CFG_SYNC_MINOR: pattern.version_minor = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_stream_byte(in_byte);
      if (out_valid && out_ready) begin
        got = {out_body_byte, out_message_kind, out_first_of_message,
               out_last_of_message, out_hello_done};
        if (extracts_due.size() == 0) begin
          note_mismatch(1'b0, got, got);
        end else begin
          want = extracts_due.pop_front();
          if (got.body_byte !== want.body_byte || got.message_kind !== want.message_kind ||
              got.first_of_message !== want.first_of_message ||
              got.last_of_message !== want.last_of_message ||
              got.hello_done !== want.hello_done)
            note_mismatch(1'b1, want, got);
        end
      end
    end
    error_count      <= mismatches;
    extracts_pending <= extracts_due.size();
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the handshake message extractor with framed records, stray bytes and
// broken headers under several sync patterns, with random gaps on both
// channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module testbench;
  import tlsx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX  = 2'd3;
  localparam logic [BYTE_W-1:0]    KIND_UNLISTED_HI = 8'hff;
  localparam logic [BYTE_W-1:0]    KIND_UNLISTED_LO = 8'h00;
  localparam int                   STALL_LIMIT      = 2000;
  localparam int                   PHASE_BYTES      = 80;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    in_byte   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [BYTE_W-1:0]    out_body_byte;
  logic [BYTE_W-1:0]    out_message_kind;
  logic                 out_first_of_message;
  logic                 out_last_of_message;
  logic                 out_hello_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data  = '0;

  int        error_count;
  int        extracts_pending;
  int        quiet_cycles = 0;
  int        bytes_sent   = 0;
  logic      calm         = 1'b0;
  sync_cfg_t sync_pat     = {SYNC_TYPE_RST, SYNC_MAJOR_RST, SYNC_MINOR_RST};

  tls_handshake_message_extractor_top i_dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_byte,
    .out_valid, .out_ready, .out_body_byte, .out_message_kind,
    .out_first_of_message, .out_last_of_message, .out_hello_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  handshake_extract_checker i_checker (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_byte,
    .out_valid, .out_ready, .out_body_byte, .out_message_kind,
    .out_first_of_message, .out_last_of_message, .out_hello_done,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .error_count, .extracts_pending
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  // Stray bytes never carry the last pattern byte, so they cannot complete a
  // header on their own and the framing stays where the stimulus expects it.
  function automatic logic [BYTE_W-1:0] stray_byte();
    logic [BYTE_W-1:0] b;
    do begin
      case ($urandom_range(3))
        0:       b = sync_pat.content_type;
        1:       b = sync_pat.version_major;
        default: b = BYTE_W'($urandom);
      endcase
    end while (b == sync_pat.version_minor);
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] body_fill();
    case ($urandom_range(9))
      0:       return sync_pat.content_type;
      1:       return sync_pat.version_major;
      2:       return sync_pat.version_minor;
      3:       return KIND_HELLO_DONE;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_stray(input int count);
    repeat (count) send_byte(stray_byte());
  endtask

  // With pattern_tail set, the body ends in the first two pattern bytes.
  task automatic send_record(input logic [BYTE_W-1:0] kind, input logic [LEN_W-1:0] len,
                             input logic pattern_tail);
    int n;
    n = int'(len);
    send_byte(sync_pat.content_type);
    send_byte(sync_pat.version_major);
    send_byte(sync_pat.version_minor);
    send_byte(BYTE_W'($urandom));
    send_byte(BYTE_W'($urandom));
    send_byte(kind);
    send_byte(len[23:16]);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int i = 0; i < n; i++) begin
      if (pattern_tail && i == n - 2)
        send_byte(sync_pat.content_type);
      else if (pattern_tail && i == n - 1)
        send_byte(sync_pat.version_major);
      else
        send_byte(body_fill());
    end
  endtask

  task automatic send_random_item();
    int                pick;
    logic [BYTE_W-1:0] kind;
    logic [LEN_W-1:0]  len;
    pick = $urandom_range(99);
    if (pick < 65) begin
      case ($urandom_range(9))
        0, 1:    kind = KIND_SERVER_HELLO;
        2:       kind = KIND_CERTIFICATE;
        3:       kind = KIND_CERT_STATUS;
        4, 5:    kind = KIND_KEY_EXCHANGE;
        default: begin
          // Any other type, except the one that ends the stream.
          do kind = BYTE_W'($urandom); while (kind == KIND_HELLO_DONE);
        end
      endcase
      if ($urandom_range(7) == 0)
        len = '0;
      else if ($urandom_range(15) == 0)
        len = LEN_W'($urandom_range(13, 40));
      else
        len = LEN_W'($urandom_range(1, 12));
      send_record(kind, len, len >= 2 && $urandom_range(4) == 0);
    end else if (pick < 80) begin
      send_stray($urandom_range(2, 6));
    end else begin
      // A header that breaks off after one or two bytes.
      send_byte(sync_pat.content_type);
      if ($urandom_range(1)) send_byte(sync_pat.version_major);
      send_stray($urandom_range(2, 4));
    end
  endtask

  task automatic run_random_phase(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_item();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (extracts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic load_pattern(input sync_cfg_t p);
    wait_drained();
    sync_pat = p;
    cfg_write(CFG_SYNC_TYPE, p.content_type);
    cfg_write(CFG_SPARE_INDEX, BYTE_W'($urandom));
    cfg_write(CFG_SYNC_MAJOR, p.version_major);
    cfg_write(CFG_SYNC_MINOR, p.version_minor);
    cfg_valid <= 1'b0;
    // The search window may still hold bytes sent under the old pattern.
    send_stray(2);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(sync_pat.content_type);
    send_byte(sync_pat.version_major);
    send_stray(2);
    send_record(KIND_SERVER_HELLO, 24'd1, 1'b0);
    send_record(KIND_CERTIFICATE, 24'd5, 1'b1);
    // The body tail plus this byte must not count as a header.
    send_byte(sync_pat.version_minor);
    send_stray(2);
    send_record(KIND_CERT_STATUS, 24'd0, 1'b0);
    send_record(KIND_KEY_EXCHANGE, 24'd2, 1'b0);
    send_record(KIND_UNLISTED_HI, 24'd3, 1'b0);
    send_record(KIND_UNLISTED_LO, 24'd1, 1'b0);
    run_random_phase(PHASE_BYTES);

    load_pattern({8'h00, 8'h00, 8'h00});
    run_random_phase(PHASE_BYTES);

    load_pattern({8'hff, 8'hff, 8'hff});
    calm = 1'b1;
    run_random_phase(PHASE_BYTES);
    calm = 1'b0;

    load_pattern({BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom)});
    run_random_phase(PHASE_BYTES);
    // A long body carries across the middle byte of the length counter.
    send_record(KIND_CERT_STATUS, 24'h000101, 1'b1);

    load_pattern({SYNC_TYPE_RST, SYNC_MAJOR_RST, SYNC_MINOR_RST});
    run_random_phase(PHASE_BYTES);

    // Server hello done closes the stream; its body and all later bytes are dropped.
    send_record(KIND_HELLO_DONE, LEN_W'($urandom_range(1, 8)), 1'b0);
    send_record(KIND_SERVER_HELLO, 24'd2, 1'b0);
    wait_drained();

    if (error_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
